/* rtl/ccis_pkg.sv */
// Shared types, constants and result builders for the clock chip init sequencer.
// Used by ccis_table and clock_chip_init_sequencer_unit; depends on nothing.
`default_nettype none

package ccis_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 512;

    // Item commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DONE  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_OK    = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_ENTRY_COUNT    = 2'd1;
    localparam logic [1:0] CFG_WAIT_TICKS     = 2'd2;

    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd112;
    localparam logic [9:0]  ENTRY_COUNT_RST    = 10'd0;
    localparam logic [23:0] WAIT_TICKS_RST     = 24'd25;

    // Chip registers and values
    localparam logic [7:0] REG_OUT_EN  = 8'd230;
    localparam logic [7:0] OUT_ALL_OFF = 8'h0F;
    localparam logic [7:0] REG_LOL     = 8'd241;
    localparam logic [7:0] LOL_PAUSE   = 8'hE5;
    localparam logic [7:0] LOL_RUN     = 8'h65;
    localparam logic [7:0] REG_SRST    = 8'd246;
    localparam logic [7:0] SRST_GO     = 8'h02;
    localparam logic [7:0] REG_OVRD    = 8'd49;
    localparam logic [7:0] OVRD_BIT    = 8'h80;
    localparam logic [7:0] REG_STATUS  = 8'd218;
    localparam logic [7:0] LOS_BIT     = 8'h04;
    localparam logic [7:0] LOCK_BITS   = 8'h15;
    localparam logic [7:0] REG_FCAL1   = 8'd235;
    localparam logic [7:0] REG_FCAL2   = 8'd236;
    localparam logic [7:0] REG_FCAL3   = 8'd237;
    localparam logic [7:0] REG_ACT1    = 8'd45;
    localparam logic [7:0] REG_ACT2    = 8'd46;
    localparam logic [7:0] REG_ACT3    = 8'd47;
    localparam logic [7:0] KEEP_HIGH   = 8'hFC;
    localparam logic [7:0] TAKE_LOW    = 8'h03;
    localparam logic [7:0] MASK_SKIP   = 8'h00;
    localparam logic [7:0] MASK_FULL   = 8'hFF;

    typedef struct packed {
        logic [1:0] command;
        logic [8:0] entry_index;
        logic [7:0] entry_address;
        logic [7:0] entry_value;
        logic [7:0] entry_mask;
        logic       bus_error;
        logic [7:0] read_data;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] bus_device;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic [8:0] failed_index;
    } result_t;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] value;
        logic [7:0] mask;
    } entry_t;

    function automatic result_t make_req(logic [1:0] kind, logic [6:0] dev,
                                         logic [7:0] addr, logic [7:0] data);
        result_t r;
        r.kind         = kind;
        r.bus_device   = dev;
        r.reg_address  = addr;
        r.write_data   = (kind == KIND_WRITE) ? data : 8'd0;
        r.failed_index = 9'd0;
        return r;
    endfunction

    function automatic result_t make_end(logic [1:0] kind, logic [8:0] fidx);
        result_t r;
        r.kind         = kind;
        r.bus_device   = 7'd0;
        r.reg_address  = 8'd0;
        r.write_data   = 8'd0;
        r.failed_index = fidx;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ccis_table.sv */
// Entry table: one write port, one read port with registered read data.
// Depends on ccis_pkg for the entry type.
`default_nettype none

module ccis_table
    import ccis_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/clock_chip_init_sequencer_unit.sv */
// A result word registers in the cycle after the item that causes it, except that a step into
// or through the entry phase first reads the table once per slot inspected, and a masked entry
// reads its table slot again before its merge write.
// Throughput: one item per cycle; input stalls during those table reads and while a result
// word waits under result_stall.
// Reset: asynchronous, active low; clears control, restores configuration defaults, not the table.
`default_nettype none

module clock_chip_init_sequencer_unit
    import ccis_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIS_OUT, ST_PAUSE_LOL, ST_ENT_WR, ST_ENT_RD, ST_LOS_RD,
        ST_OVR_RD1, ST_OVR_WR1, ST_SRST, ST_LOL_ON, ST_WAIT, ST_LOCK_RD,
        ST_F1_RD, ST_A1_WR, ST_F2_RD, ST_A2_WR, ST_A3_RD, ST_F3_RD, ST_A3_WR,
        ST_OVR_RD2, ST_OVR_WR2
    } step_t;

    typedef enum logic [1:0] {
        PH_IDLE, PH_SCAN, PH_MERGE
    } phase_t;

    step_t          step_reg, step_next;
    phase_t         phase_reg, phase_next;
    logic [CW-1:0]  cursor_reg, cursor_next;
    logic [7:0]     held_reg, held_next;
    logic [7:0]     rd_reg, rd_next;
    logic [23:0]    wait_reg, wait_next;
    logic           result_valid_reg, result_valid_next;
    result_t        result_reg, result_next;
    logic [6:0]     device_address_reg;
    logic [9:0]     entry_count_reg;
    logic [23:0]    wait_ticks_reg;

    logic           item_fire;
    logic [CW-1:0]  limit;
    logic [31:0]    cursor_wide;
    logic [23:0]    wait_dec;
    logic           tbl_wr_en;
    logic           tbl_rd_en;
    logic [AW-1:0]  tbl_rd_addr;
    entry_t         tbl_rd_data;
    entry_t         load_entry;
    logic           scan_go;
    logic [CW-1:0]  scan_cur;
    logic           emit;
    result_t        emit_word;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (phase_reg != PH_IDLE) || (result_valid_reg && result_stall);
    assign item_fire    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cursor_wide  = 32'(cursor_reg);
    assign wait_dec     = (wait_reg != 24'd0) ? (wait_reg - 24'd1) : 24'd0;

    assign load_entry.address = item.entry_address;
    assign load_entry.value   = item.entry_value;
    assign load_entry.mask    = item.entry_mask;
    assign tbl_wr_en = item_fire && (item.command == CMD_LOAD)
                       && (32'(item.entry_index) < TABLE_DEPTH);

    always_comb
    begin
        if (32'(entry_count_reg) > TABLE_DEPTH)
        begin
            limit = CW'(TABLE_DEPTH);
        end
        else
        begin
            limit = CW'(entry_count_reg);
        end
    end

    ccis_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(item.entry_index)),
        .wr_data (load_entry),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    always_comb
    begin
        step_next   = step_reg;
        phase_next  = phase_reg;
        cursor_next = cursor_reg;
        held_next   = held_reg;
        rd_next     = rd_reg;
        wait_next   = wait_reg;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = '0;
        scan_go     = 1'b0;
        scan_cur    = cursor_reg;
        emit        = 1'b0;
        emit_word   = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item_fire)
                begin
                    case (item.command)
                        CMD_START:
                        begin
                            if (step_reg == ST_IDLE)
                            begin
                                cursor_next = '0;
                                emit        = 1'b1;
                                emit_word   = make_req(KIND_WRITE, device_address_reg,
                                                       REG_OUT_EN, OUT_ALL_OFF);
                                step_next   = ST_DIS_OUT;
                            end
                        end
                        CMD_DONE:
                        begin
                            if (step_reg != ST_IDLE && step_reg != ST_WAIT)
                            begin
                                if (item.bus_error)
                                begin
                                    emit      = 1'b1;
                                    emit_word = make_end(KIND_ERR,
                                        (step_reg == ST_ENT_WR || step_reg == ST_ENT_RD)
                                        ? cursor_wide[8:0] : 9'd0);
                                    step_next = ST_IDLE;
                                end
                                else
                                begin
                                    case (step_reg)
                                        ST_DIS_OUT:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_LOL, LOL_PAUSE);
                                            step_next = ST_PAUSE_LOL;
                                        end
                                        ST_PAUSE_LOL:
                                        begin
                                            scan_go  = 1'b1;
                                            scan_cur = '0;
                                        end
                                        ST_ENT_WR:
                                        begin
                                            scan_go  = 1'b1;
                                            scan_cur = cursor_reg + CW'(1);
                                        end
                                        ST_ENT_RD:
                                        begin
                                            if (cursor_wide >= TABLE_DEPTH)
                                            begin
                                                scan_go = 1'b1;
                                            end
                                            else
                                            begin
                                                // Refetch the entry: a load may have changed it.
                                                tbl_rd_en   = 1'b1;
                                                tbl_rd_addr = AW'(cursor_reg);
                                                rd_next     = item.read_data;
                                                phase_next  = PH_MERGE;
                                            end
                                        end
                                        ST_LOS_RD:
                                        begin
                                            emit = 1'b1;
                                            if ((item.read_data & LOS_BIT) != 8'd0)
                                            begin
                                                emit_word = make_req(KIND_READ,
                                                    device_address_reg, REG_STATUS, 8'd0);
                                            end
                                            else
                                            begin
                                                emit_word = make_req(KIND_READ,
                                                    device_address_reg, REG_OVRD, 8'd0);
                                                step_next = ST_OVR_RD1;
                                            end
                                        end
                                        ST_OVR_RD1:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_OVRD,
                                                item.read_data & ~OVRD_BIT);
                                            step_next = ST_OVR_WR1;
                                        end
                                        ST_OVR_WR1:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_SRST, SRST_GO);
                                            step_next = ST_SRST;
                                        end
                                        ST_SRST:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_LOL, LOL_RUN);
                                            step_next = ST_LOL_ON;
                                        end
                                        ST_LOL_ON:
                                        begin
                                            wait_next = wait_ticks_reg;
                                            if (wait_ticks_reg == 24'd0)
                                            begin
                                                emit      = 1'b1;
                                                emit_word = make_req(KIND_READ,
                                                    device_address_reg, REG_STATUS, 8'd0);
                                                step_next = ST_LOCK_RD;
                                            end
                                            else
                                            begin
                                                step_next = ST_WAIT;
                                            end
                                        end
                                        ST_LOCK_RD:
                                        begin
                                            emit = 1'b1;
                                            if ((item.read_data & LOCK_BITS) != 8'd0)
                                            begin
                                                emit_word = make_req(KIND_READ,
                                                    device_address_reg, REG_STATUS, 8'd0);
                                            end
                                            else
                                            begin
                                                emit_word = make_req(KIND_READ,
                                                    device_address_reg, REG_FCAL1, 8'd0);
                                                step_next = ST_F1_RD;
                                            end
                                        end
                                        ST_F1_RD:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_ACT1, item.read_data);
                                            step_next = ST_A1_WR;
                                        end
                                        ST_A1_WR:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_READ,
                                                device_address_reg, REG_FCAL2, 8'd0);
                                            step_next = ST_F2_RD;
                                        end
                                        ST_F2_RD:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_ACT2, item.read_data);
                                            step_next = ST_A2_WR;
                                        end
                                        ST_A2_WR:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_READ,
                                                device_address_reg, REG_ACT3, 8'd0);
                                            step_next = ST_A3_RD;
                                        end
                                        ST_A3_RD:
                                        begin
                                            held_next = item.read_data;
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_READ,
                                                device_address_reg, REG_FCAL3, 8'd0);
                                            step_next = ST_F3_RD;
                                        end
                                        ST_F3_RD:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_ACT3,
                                                (held_reg & KEEP_HIGH)
                                                | (item.read_data & TAKE_LOW));
                                            step_next = ST_A3_WR;
                                        end
                                        ST_A3_WR:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_READ,
                                                device_address_reg, REG_OVRD, 8'd0);
                                            step_next = ST_OVR_RD2;
                                        end
                                        ST_OVR_RD2:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_req(KIND_WRITE,
                                                device_address_reg, REG_OVRD,
                                                item.read_data | OVRD_BIT);
                                            step_next = ST_OVR_WR2;
                                        end
                                        ST_OVR_WR2:
                                        begin
                                            emit      = 1'b1;
                                            emit_word = make_end(KIND_OK, 9'd0);
                                            step_next = ST_IDLE;
                                        end
                                        default:
                                        begin
                                            step_next = ST_IDLE;
                                        end
                                    endcase
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (step_reg == ST_WAIT)
                            begin
                                wait_next = wait_dec;
                                if (wait_dec == 24'd0)
                                begin
                                    emit      = 1'b1;
                                    emit_word = make_req(KIND_READ, device_address_reg,
                                                         REG_STATUS, 8'd0);
                                    step_next = ST_LOCK_RD;
                                end
                            end
                        end
                        default:
                        begin
                            // Loads go straight to the table write port.
                        end
                    endcase
                end
            end
            PH_SCAN:
            begin
                if (tbl_rd_data.mask == MASK_SKIP)
                begin
                    scan_go  = 1'b1;
                    scan_cur = cursor_reg + CW'(1);
                end
                else if (tbl_rd_data.mask == MASK_FULL)
                begin
                    emit       = 1'b1;
                    emit_word  = make_req(KIND_WRITE, device_address_reg,
                                          tbl_rd_data.address, tbl_rd_data.value);
                    step_next  = ST_ENT_WR;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_word  = make_req(KIND_READ, device_address_reg,
                                          tbl_rd_data.address, 8'd0);
                    step_next  = ST_ENT_RD;
                    phase_next = PH_IDLE;
                end
            end
            PH_MERGE:
            begin
                emit       = 1'b1;
                emit_word  = make_req(KIND_WRITE, device_address_reg, tbl_rd_data.address,
                                      (rd_reg & ~tbl_rd_data.mask)
                                      | (tbl_rd_data.value & tbl_rd_data.mask));
                step_next  = ST_ENT_WR;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Advance the entry walk: fetch the next slot or leave for the input-loss poll.
        if (scan_go)
        begin
            cursor_next = scan_cur;
            if (scan_cur < limit)
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = AW'(scan_cur);
                phase_next  = PH_SCAN;
            end
            else
            begin
                emit       = 1'b1;
                emit_word  = make_req(KIND_READ, device_address_reg, REG_STATUS, 8'd0);
                step_next  = ST_LOS_RD;
                phase_next = PH_IDLE;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
            result_next       = emit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg           <= ST_IDLE;
            phase_reg          <= PH_IDLE;
            cursor_reg         <= '0;
            held_reg           <= '0;
            rd_reg             <= '0;
            wait_reg           <= '0;
            result_valid_reg   <= 1'b0;
            result_reg         <= '0;
            device_address_reg <= DEVICE_ADDRESS_RST;
            entry_count_reg    <= ENTRY_COUNT_RST;
            wait_ticks_reg     <= WAIT_TICKS_RST;
        end
        else
        begin
            step_reg         <= step_next;
            phase_reg        <= phase_next;
            cursor_reg       <= cursor_next;
            held_reg         <= held_next;
            rd_reg           <= rd_next;
            wait_reg         <= wait_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[6:0];
                    CFG_ENTRY_COUNT:    entry_count_reg    <= cfg_data[9:0];
                    CFG_WAIT_TICKS:     wait_ticks_reg     <= cfg_data;
                    default:
                    begin
                        // Drop writes beyond the register list.
                    end
                endcase
            end
        end
    end

`ifndef SYNTH
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> item_stall)
        else $error("item accepted during a table access");

    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SCAN || phase_reg == PH_MERGE) |-> $past(tbl_rd_en))
        else $error("table data used without a read the cycle before");

    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SCAN) |-> (step_reg == ST_PAUSE_LOL || step_reg == ST_ENT_WR))
        else $error("entry walk outside the entry phase");

    a_merge_step: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MERGE) |-> (step_reg == ST_ENT_RD))
        else $error("merge write without a pending entry read");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.kind == KIND_OK || result_reg.kind == KIND_ERR))
        |-> (step_reg == ST_IDLE))
        else $error("final status word while the run is still active");
`endif

endmodule

`default_nettype wire

/* verif/clock_chip_init_sequencer_unit_test.sv */
// Testbench for clock_chip_init_sequencer_unit: answers its bus requests, predicts every word.
// Depends on ccis_pkg and the sequencer RTL only.
`timescale 1ns / 100ps

module clock_chip_init_sequencer_unit_test;
    import ccis_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 600;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_WAIT     = 1000;

    typedef enum logic [4:0] {
        S_IDLE, S_DISABLE, S_PAUSE, S_ENTRY_WRITE, S_ENTRY_READ, S_LOS_POLL,
        S_OVR_READ1, S_OVR_WRITE1, S_SOFT_RESET, S_LOL_RUN, S_WAIT, S_LOCK_POLL,
        S_CAL1_READ, S_ACT1_WRITE, S_CAL2_READ, S_ACT2_WRITE, S_ACT3_READ,
        S_CAL3_READ, S_ACT3_WRITE, S_OVR_READ2, S_OVR_WRITE2
    } seq_step_t;

    class bus_sequence_board;
        entry_t      slots [DEPTH];
        bit          loaded [DEPTH];
        int          prefix;
        seq_step_t   step;
        logic [9:0]  cursor;
        logic [7:0]  held;
        logic [23:0] wait_left;
        logic [6:0]  dev;
        logic [9:0]  count;
        logic [23:0] ticks;
        result_t     pending_words [$];
        int          errors;

        function new();
            prefix    = 0;
            step      = S_IDLE;
            cursor    = '0;
            held      = '0;
            wait_left = '0;
            dev       = DEVICE_ADDRESS_RST;
            count     = ENTRY_COUNT_RST;
            ticks     = WAIT_TICKS_RST;
            errors    = 0;
        endfunction

        function result_t request(logic [1:0] kind, logic [7:0] addr, logic [7:0] data,
                                  seq_step_t nxt);
            result_t r;
            step           = nxt;
            r.kind         = kind;
            r.bus_device   = dev;
            r.reg_address  = addr;
            r.write_data   = (kind == KIND_WRITE) ? data : 8'd0;
            r.failed_index = '0;
            return r;
        endfunction

        function result_t finish(logic [1:0] kind, logic [8:0] fidx);
            result_t r;
            step           = S_IDLE;
            r.kind         = kind;
            r.bus_device   = '0;
            r.reg_address  = '0;
            r.write_data   = '0;
            r.failed_index = fidx;
            return r;
        endfunction

        // Skip masked-off slots, then request the next entry or the input-loss poll.
        function result_t scan_entries();
            entry_t e;
            int limit;
            limit = (count > DEPTH) ? DEPTH : count;
            while (cursor < limit)
            begin
                e = slots[cursor];
                if (e.mask == MASK_SKIP)
                begin
                    cursor++;
                    continue;
                end
                if (e.mask == MASK_FULL)
                    return request(KIND_WRITE, e.address, e.value, S_ENTRY_WRITE);
                return request(KIND_READ, e.address, 8'd0, S_ENTRY_READ);
            end
            return request(KIND_READ, REG_STATUS, 8'd0, S_LOS_POLL);
        endfunction

        function bit advance_on_done(item_t w, output result_t r);
            logic [7:0] rd;
            entry_t e;
            rd = w.read_data;
            if (step == S_IDLE || step == S_WAIT)
                return 0;
            if (w.bus_error)
            begin
                r = finish(KIND_ERR, (step == S_ENTRY_WRITE || step == S_ENTRY_READ) ?
                           cursor[8:0] : 9'd0);
                return 1;
            end
            case (step)
                S_DISABLE:     r = request(KIND_WRITE, REG_LOL, LOL_PAUSE, S_PAUSE);
                S_PAUSE:
                begin
                    cursor = '0;
                    r = scan_entries();
                end
                S_ENTRY_WRITE:
                begin
                    cursor++;
                    r = scan_entries();
                end
                S_ENTRY_READ:
                begin
                    if (cursor >= DEPTH)
                        r = scan_entries();
                    else
                    begin
                        e = slots[cursor];
                        r = request(KIND_WRITE, e.address,
                                    (rd & ~e.mask) | (e.value & e.mask), S_ENTRY_WRITE);
                    end
                end
                S_LOS_POLL:
                begin
                    if ((rd & LOS_BIT) != 0)
                        r = request(KIND_READ, REG_STATUS, 8'd0, S_LOS_POLL);
                    else
                        r = request(KIND_READ, REG_OVRD, 8'd0, S_OVR_READ1);
                end
                S_OVR_READ1:   r = request(KIND_WRITE, REG_OVRD, rd & ~OVRD_BIT, S_OVR_WRITE1);
                S_OVR_WRITE1:  r = request(KIND_WRITE, REG_SRST, SRST_GO, S_SOFT_RESET);
                S_SOFT_RESET:  r = request(KIND_WRITE, REG_LOL, LOL_RUN, S_LOL_RUN);
                S_LOL_RUN:
                begin
                    wait_left = ticks;
                    if (wait_left != 0)
                    begin
                        step = S_WAIT;
                        return 0;
                    end
                    r = request(KIND_READ, REG_STATUS, 8'd0, S_LOCK_POLL);
                end
                S_LOCK_POLL:
                begin
                    if ((rd & LOCK_BITS) != 0)
                        r = request(KIND_READ, REG_STATUS, 8'd0, S_LOCK_POLL);
                    else
                        r = request(KIND_READ, REG_FCAL1, 8'd0, S_CAL1_READ);
                end
                S_CAL1_READ:   r = request(KIND_WRITE, REG_ACT1, rd, S_ACT1_WRITE);
                S_ACT1_WRITE:  r = request(KIND_READ, REG_FCAL2, 8'd0, S_CAL2_READ);
                S_CAL2_READ:   r = request(KIND_WRITE, REG_ACT2, rd, S_ACT2_WRITE);
                S_ACT2_WRITE:  r = request(KIND_READ, REG_ACT3, 8'd0, S_ACT3_READ);
                S_ACT3_READ:
                begin
                    held = rd;
                    r = request(KIND_READ, REG_FCAL3, 8'd0, S_CAL3_READ);
                end
                S_CAL3_READ:
                    r = request(KIND_WRITE, REG_ACT3, (held & KEEP_HIGH) | (rd & TAKE_LOW),
                                S_ACT3_WRITE);
                S_ACT3_WRITE:  r = request(KIND_READ, REG_OVRD, 8'd0, S_OVR_READ2);
                S_OVR_READ2:   r = request(KIND_WRITE, REG_OVRD, rd | OVRD_BIT, S_OVR_WRITE2);
                S_OVR_WRITE2:  r = finish(KIND_OK, 9'd0);
                default:
                begin
                    step = S_IDLE;
                    return 0;
                end
            endcase
            return 1;
        endfunction

        function void note_word(item_t w);
            result_t r;
            bit produced;
            produced = 0;
            case (w.command)
                CMD_LOAD:
                begin
                    slots[w.entry_index]  = {w.entry_address, w.entry_value, w.entry_mask};
                    loaded[w.entry_index] = 1'b1;
                    while (prefix < DEPTH && loaded[prefix])
                        prefix++;
                end
                CMD_START:
                begin
                    if (step == S_IDLE)
                    begin
                        cursor   = '0;
                        r        = request(KIND_WRITE, REG_OUT_EN, OUT_ALL_OFF, S_DISABLE);
                        produced = 1;
                    end
                end
                CMD_DONE:
                    produced = advance_on_done(w, r);
                default:
                begin
                    if (step == S_WAIT)
                    begin
                        if (wait_left > 0)
                            wait_left--;
                        if (wait_left == 0)
                        begin
                            r        = request(KIND_READ, REG_STATUS, 8'd0, S_LOCK_POLL);
                            produced = 1;
                        end
                    end
                end
            endcase
            if (produced)
                pending_words.push_back(r);
        endfunction

        task log_mismatch(string msg);
            errors++;
            if (errors <= 50)
                $display("mismatch: %s", msg);
        endtask

        task check_word(result_t got);
            result_t want;
            if (pending_words.size() == 0)
            begin
                log_mismatch($sformatf("unexpected word kind %0d reg %0h", got.kind,
                                       got.reg_address));
                return;
            end
            want = pending_words.pop_front();
            if (got.kind !== want.kind)
                log_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.bus_device !== want.bus_device)
                log_mismatch($sformatf("bus_device got %0h want %0h", got.bus_device,
                                       want.bus_device));
            if (got.reg_address !== want.reg_address)
                log_mismatch($sformatf("reg_address got %0h want %0h", got.reg_address,
                                       want.reg_address));
            if (got.write_data !== want.write_data)
                log_mismatch($sformatf("write_data got %0h want %0h", got.write_data,
                                       want.write_data));
            if (got.failed_index !== want.failed_index)
                log_mismatch($sformatf("failed_index got %0d want %0d", got.failed_index,
                                       want.failed_index));
        endtask
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = '0;
    logic [23:0] cfg_data     = '0;

    bus_sequence_board sb;
    int send_idle;
    int recv_idle;
    int err_pm;
    int noise_pct;
    bit pressure_armed;

    clock_chip_init_sequencer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic item_t word(logic [1:0] cmd, logic [8:0] idx, logic [7:0] addr,
                                   logic [7:0] val, logic [7:0] mask, logic err,
                                   logic [7:0] rd);
        item_t w;
        w.command       = cmd;
        w.entry_index   = idx;
        w.entry_address = addr;
        w.entry_value   = val;
        w.entry_mask    = mask;
        w.bus_error     = err;
        w.read_data     = rd;
        return w;
    endfunction

    // Answer the sequencer like a bus would; noise words stay random apart from the two guards below.
    function automatic item_t choose_item(bit winding);
        logic [63:0] raw;
        item_t w;
        int limit;
        raw = {$urandom, $urandom};
        w   = raw[$bits(item_t)-1:0];
        if (winding || $urandom_range(99) >= noise_pct)
        begin
            if (sb.step == S_IDLE)
                w.command = ($urandom_range(99) < 35) ? CMD_LOAD : CMD_START;
            else if (sb.step == S_WAIT)
                w.command = ($urandom_range(99) < 90) ? CMD_TICK : CMD_LOAD;
            else
            begin
                w.command   = ($urandom_range(99) < 8) ? CMD_LOAD : CMD_DONE;
                w.bus_error = ($urandom_range(999) < err_pm);
                if (sb.step == S_LOCK_POLL && $urandom_range(99) < 60)
                    w.read_data &= ~LOCK_BITS;
            end
            if (w.command == CMD_LOAD)
            begin
                if (sb.prefix < DEPTH && $urandom_range(1) == 1)
                    w.entry_index = 9'(sb.prefix);
                case ($urandom_range(2))
                    0:       w.entry_mask = MASK_SKIP;
                    1:       w.entry_mask = MASK_FULL;
                    default: ;
                endcase
            end
        end
        // Never let a run reach a slot that was never loaded.
        limit = (sb.count > DEPTH) ? DEPTH : sb.count;
        if (w.command == CMD_START && sb.step == S_IDLE && sb.prefix < limit)
        begin
            w.command     = CMD_LOAD;
            w.entry_index = 9'(sb.prefix);
        end
        // Fail the restart write rather than sit out a huge wait.
        if (w.command == CMD_DONE && sb.step == S_LOL_RUN && sb.ticks > LONG_WAIT)
            w.bus_error = 1'b1;
        return w;
    endfunction

    task automatic send_word(input item_t w);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        sb.note_word(w);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEVICE_ADDRESS: sb.dev   = data[6:0];
            CFG_ENTRY_COUNT:    sb.count = data[9:0];
            CFG_WAIT_TICKS:     sb.ticks = data;
            default:            ;
        endcase
    endtask

    // Drop valid, wait out every expected word, then let any table scan finish.
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [6:0] dev, input int count_want,
                             input logic [23:0] ticks, input int budget, input int err,
                             input int noise);
        int cap;
        cap = count_want;
        if (sb.prefix < DEPTH && cap > sb.prefix)
            cap = sb.prefix;
        write_reg(CFG_DEVICE_ADDRESS, {17'd0, dev});
        write_reg(CFG_ENTRY_COUNT, 24'(cap));
        write_reg(CFG_WAIT_TICKS, ticks);
        err_pm    = err;
        noise_pct = noise;
        repeat (budget) send_word(choose_item(1'b0));
        while (sb.step != S_IDLE)
            send_word(choose_item(1'b1));
        settle();
    endtask

    task automatic fill_table();
        int pick;
        logic [7:0] m;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!sb.loaded[i])
            begin
                pick = $urandom_range(9);
                m = (pick < 6) ? MASK_SKIP : (pick < 8) ? MASK_FULL : 8'($urandom);
                send_word(word(CMD_LOAD, 9'(i), 8'($urandom), 8'($urandom), m, 1'b0, 8'd0));
            end
        end
        settle();
    endtask

    task automatic directed_run();
        write_reg(CFG_DEVICE_ADDRESS, 24'd127);
        write_reg(CFG_ENTRY_COUNT, 24'd3);
        write_reg(CFG_WAIT_TICKS, 24'd0);
        err_pm    = 0;
        noise_pct = 0;
        // Completion and tick with nothing running: both dropped.
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF));
        send_word(word(CMD_TICK, 9'd511, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
        send_word(word(CMD_LOAD, 9'd0, 8'h00, 8'hFF, MASK_FULL, 1'b0, 8'h00));
        send_word(word(CMD_LOAD, 9'd1, 8'hFF, 8'h00, MASK_SKIP, 1'b0, 8'h00));
        send_word(word(CMD_LOAD, 9'd2, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00));
        send_word(word(CMD_LOAD, 9'd511, 8'hFF, 8'hFF, MASK_FULL, 1'b0, 8'h00));
        send_word(word(CMD_START, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_word(word(CMD_START, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF));
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        // Fail the merge read of slot 2.
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF));
        send_word(word(CMD_START, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        // Reload slot 2 before the run reaches it.
        send_word(word(CMD_LOAD, 9'd2, 8'h33, 8'hCC, MASK_FULL, 1'b0, 8'h00));
        send_word(word(CMD_TICK, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_word(word(CMD_DONE, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        while (sb.step != S_IDLE)
            send_word(choose_item(1'b1));
        settle();
    endtask

    initial
    begin
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_word(result);
            if (pressure_armed && !held_once && result_valid)
            begin
                held_once = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        sb             = new();
        send_idle      = 27;
        recv_idle      = 73;
        err_pm         = 0;
        noise_pct      = 0;
        pressure_armed = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        directed_run();
        run_phase(7'($urandom), 0, 24'd3, 250, 20, 10);
        run_phase(7'd0, 30, 24'hFFFFFF, 150, 10, 10);

        send_idle = 73;
        recv_idle = 27;
        run_phase(7'($urandom), $urandom_range(64), 24'd1, 250, 20, 10);
        fill_table();
        run_phase(7'd127, 1023, 24'd0, 350, 1, 3);

        send_idle      = 0;
        recv_idle      = 0;
        pressure_armed = 1;
        run_phase(7'($urandom), 512, 24'd25, 200, 5, 5);
        run_phase(7'($urandom), $urandom_range(40), 24'($urandom_range(15, 1)), 200, 20, 10);

        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ccis_pkg.sv
rtl/ccis_table.sv
rtl/clock_chip_init_sequencer_unit.sv
verif/clock_chip_init_sequencer_unit_test.sv
